/* rtl/core/swm_pkg.sv */
// ----------------------------------------------------------------------------
// swm_pkg
// Shared types and constants for the sliding-window median core.
// ----------------------------------------------------------------------------
`default_nettype none

package swm_pkg;

  localparam int CFG_W = 7;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic del;   // drop the oldest entry
    logic ins;   // insert the request's sample
  } swm_ctrl_t;

endpackage

`default_nettype wire

/* rtl/core/swm_cell.sv */
// ----------------------------------------------------------------------------
// swm_cell
// One slot of the sorted window: holds a value and its age, and updates
// from its own contents and its two neighbors on delete and insert.
// ----------------------------------------------------------------------------
`default_nettype none

module swm_cell #(
  parameter int SAMPLE_WIDTH = 32,
  parameter int AGE_W        = 6,
  parameter int FILL_W       = 7,
  parameter int IDX          = 0
) (
  input  wire                           clk,
  input  swm_pkg::swm_ctrl_t            ctrl,
  input  wire signed [SAMPLE_WIDTH-1:0] sample,
  input  wire        [AGE_W-1:0]        oldest_age,
  input  wire        [FILL_W-1:0]       fill_cur,
  input  wire        [FILL_W-1:0]       fill_pd,
  input  wire                           shift_left,
  input  wire signed [SAMPLE_WIDTH-1:0] right_val,
  input  wire        [AGE_W-1:0]        right_age,
  input  wire signed [SAMPLE_WIDTH-1:0] left_pval,
  input  wire        [AGE_W-1:0]        left_page,
  input  wire                           left_pge,
  output logic                          hit,
  output logic signed [SAMPLE_WIDTH-1:0] pval,
  output logic       [AGE_W-1:0]        page,
  output logic                          pge,
  output logic signed [SAMPLE_WIDTH-1:0] val,
  output logic       [AGE_W-1:0]        age
);

  localparam logic [FILL_W-1:0] MY_IDX = FILL_W'(IDX);

  logic signed [SAMPLE_WIDTH-1:0] val_r, val_nxt;
  logic        [AGE_W-1:0]        age_r, age_nxt;

  // oldest entry of the current window
  assign hit = ctrl.del && (MY_IDX < fill_cur) && (age_r == oldest_age);

  // contents after the delete step
  assign pval = shift_left ? right_val : val_r;
  assign page = shift_left ? right_age : age_r;
  assign pge  = (MY_IDX < fill_pd) && (sample >= pval);

  always_comb begin
    val_nxt = val_r;
    age_nxt = age_r;
    if (ctrl.ins) begin
      if (pge) begin
        val_nxt = pval;
        age_nxt = page + AGE_W'(1);
      end else if (left_pge) begin
        val_nxt = sample;
        age_nxt = '0;
      end else begin
        val_nxt = left_pval;
        age_nxt = left_page + AGE_W'(1);
      end
    end else if (ctrl.del) begin
      val_nxt = pval;
      age_nxt = page;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    age_r <= age_nxt;
  end

  assign val = val_r;
  assign age = age_r;

endmodule

`default_nettype wire

/* rtl/core/sliding_window_median_core.sv */
// ----------------------------------------------------------------------------
// sliding_window_median_core
// Running lower-median filter over the last window_size samples, kept in a
// sorted chain of cells with per-entry ages.
// ----------------------------------------------------------------------------
//  channel | ports                          | contents
//  in      | in_tvalid/in_tready            | tdata: sample, tuser: start_of_sequence
//  out     | out_tvalid/out_tready          | tdata: median
//  cfg     | cfg_we/cfg_wdata               | window_size
//
//  One request per cycle unless the output stalls or surplus entries remain;
//  the chain drops the oldest entry and inserts the new sample in the same cycle.
//  The median is read from the chain once the output can advance after the
//  update, then held in the output register.
//  After window_size is lowered, surplus entries are dropped one at a time,
//  oldest first, before the next request is taken.
//  rst_n is synchronous; it empties the window and sets window_size to 3.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_median_core #(
  parameter int MAX_WINDOW   = 64,
  parameter int SAMPLE_WIDTH = 32
) (
  input  wire                                     clk,
  input  wire                                     rst_n,
  input  wire                                     in_tvalid,
  output logic                                    in_tready,
  input  wire  [((SAMPLE_WIDTH+7)/8)*8-1:0]       in_tdata,   // sample
  input  wire                                     in_tuser,   // start_of_sequence
  output logic                                    out_tvalid,
  input  wire                                     out_tready,
  output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]       out_tdata,  // median
  input  wire                                     cfg_we,
  input  wire  [swm_pkg::CFG_W-1:0]               cfg_wdata
);

  localparam int TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int AGE_W   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int FILL_W  = $clog2(MAX_WINDOW + 1);
  localparam int WIDE_W  = 32;

  logic [swm_pkg::CFG_W-1:0] ws_r;
  logic [FILL_W-1:0]         fill_r, fill_nxt;
  logic                      emit_r, emit_nxt;
  logic                      out_valid_r;
  logic [SAMPLE_WIDTH-1:0]   out_data_r;

  logic [FILL_W-1:0] k, mid, fill_eff, fill_pd;
  logic              drop_need, accept, emit_adv;
  swm_pkg::swm_ctrl_t ctrl;

  logic signed [SAMPLE_WIDTH-1:0] sample;
  logic [AGE_W-1:0]               oldest_age;
  logic [MAX_WINDOW-1:0]          hit, shl;

  logic signed [SAMPLE_WIDTH-1:0] val   [MAX_WINDOW];
  logic signed [SAMPLE_WIDTH-1:0] rval  [MAX_WINDOW+1];
  logic        [AGE_W-1:0]        rage  [MAX_WINDOW+1];
  logic signed [SAMPLE_WIDTH-1:0] pval  [MAX_WINDOW+1];
  logic        [AGE_W-1:0]        page  [MAX_WINDOW+1];
  logic        [MAX_WINDOW:0]     pge;

  // effective window length
  always_comb begin
    if (ws_r == '0) begin
      k = FILL_W'(1);
    end else if (WIDE_W'(ws_r) > WIDE_W'(MAX_WINDOW)) begin
      k = FILL_W'(MAX_WINDOW);
    end else begin
      k = FILL_W'(ws_r);
    end
  end

  assign mid       = (k - FILL_W'(1)) >> 1;
  assign sample    = in_tdata[SAMPLE_WIDTH-1:0];
  assign drop_need = fill_r > k;
  assign emit_adv  = !out_valid_r || out_tready;
  assign in_tready = !drop_need && (!emit_r || emit_adv);
  assign accept    = in_tvalid && in_tready;

  assign fill_eff   = (accept && in_tuser) ? '0 : fill_r;
  assign ctrl.del   = drop_need || (accept && (fill_eff == k));
  assign ctrl.ins   = accept;
  assign fill_pd    = fill_eff - FILL_W'(ctrl.del);
  assign fill_nxt   = fill_pd + FILL_W'(ctrl.ins);
  assign oldest_age = AGE_W'(fill_r - FILL_W'(1));

  // cells at or right of the dropped entry take their right neighbor
  always_comb begin
    for (int i = 0; i < MAX_WINDOW; i++) begin
      shl[i] = |(hit & ({MAX_WINDOW{1'b1}} >> (MAX_WINDOW - 1 - i)));
    end
  end

  assign rval[MAX_WINDOW] = '0;
  assign rage[MAX_WINDOW] = '0;
  assign pval[0]          = '0;
  assign page[0]          = '0;
  assign pge[0]           = 1'b1;

  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    swm_cell #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .AGE_W        (AGE_W),
      .FILL_W       (FILL_W),
      .IDX          (i)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .sample     (sample),
      .oldest_age (oldest_age),
      .fill_cur   (fill_r),
      .fill_pd    (fill_pd),
      .shift_left (shl[i]),
      .right_val  (rval[i+1]),
      .right_age  (rage[i+1]),
      .left_pval  (pval[i]),
      .left_page  (page[i]),
      .left_pge   (pge[i]),
      .hit        (hit[i]),
      .pval       (pval[i+1]),
      .page       (page[i+1]),
      .pge        (pge[i+1]),
      .val        (val[i]),
      .age        (rage[i])
    );
    assign rval[i] = val[i];
  end

  always_comb begin
    emit_nxt = emit_r && !emit_adv;
    if (accept && (fill_nxt == k)) begin
      emit_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_r        <= swm_pkg::CFG_W'(3);
      fill_r      <= '0;
      emit_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        ws_r <= cfg_wdata;
      end
      if (ctrl.del || ctrl.ins) begin
        fill_r <= fill_nxt;
      end
      emit_r <= emit_nxt;
      if (emit_r && emit_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit_r && emit_adv) begin
      out_data_r <= val[mid[AGE_W-1:0]];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = TDATA_W'(out_data_r);

  a_fill_bound : assert property (@(posedge clk) disable iff (!rst_n)
    WIDE_W'(fill_r) <= WIDE_W'(MAX_WINDOW))
    else $error("window fill beyond capacity");

  a_one_oldest : assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.del |-> $onehot(hit))
    else $error("oldest entry not unique on drop");

  a_no_accept_overfull : assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> (fill_r <= k))
    else $error("request taken with surplus entries");

  a_fill_after_insert : assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (fill_r != '0))
    else $error("window empty after insert");

endmodule

`default_nettype wire
